@@ rtl/trpd_pkg.sv @@
package trpd_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int CFG_INDEX_W     = 2;
    localparam int PIXEL_W         = 32;
    localparam int RUN_W           = 8;
    localparam int BYTE_W          = 8;
    localparam int BPP_W           = 3;
    localparam int POS_W           = 2;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [BPP_W-1:0] BPP_MIN   = 3'd1;
    localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;
    localparam logic [BPP_W-1:0] BPP_SWAP  = 3'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RLE_ENABLE   = 2'd0,
        REG_BYTES_PER_PX = 2'd1,
        REG_IMAGE_PIXELS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               last_run;
        logic [RUN_W-1:0]   run_length;
        logic [PIXEL_W-1:0] pixel_value;
    } result_t;

endpackage

@@ rtl/trpd_core.sv @@
module trpd_core import trpd_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0] cfg_data,
    input  logic                   item_accept,
    input  logic [BYTE_W-1:0]      data_byte,
    output logic                   res_valid,
    output result_t                res
);

    logic                   rle_enable_reg, rle_enable_next;
    logic [BPP_W-1:0]       bpp_reg, bpp_next;
    logic [RUN_W-1:0]       packet_left_reg, packet_left_next;
    logic                   repeat_reg, repeat_next;
    logic [PIXEL_W-1:0]     pixel_bytes_reg, pixel_bytes_next;
    logic [POS_W-1:0]       byte_pos_reg, byte_pos_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic                   done_reg, done_next;

    logic [BPP_W-1:0]       bpp_eff;
    logic [PIXEL_W-1:0]     bytes_ins;
    logic [PIXEL_W-1:0]     px;
    logic [RUN_W-1:0]       run_raw;
    logic [RUN_W-1:0]       run_clip;
    logic [COUNT_WIDTH-1:0] remaining_sub;

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_eff = BPP_MIN;
        end else if (bpp_reg > BPP_MAX) begin
            bpp_eff = BPP_MAX;
        end else begin
            bpp_eff = bpp_reg;
        end
    end

    always_comb begin
        rle_enable_next  = rle_enable_reg;
        bpp_next         = bpp_reg;
        packet_left_next = packet_left_reg;
        repeat_next      = repeat_reg;
        pixel_bytes_next = pixel_bytes_reg;
        byte_pos_next    = byte_pos_reg;
        remaining_next   = remaining_reg;
        done_next        = done_reg;
        res_valid        = 1'b0;

        bytes_ins = pixel_bytes_reg;
        bytes_ins[BYTE_W*byte_pos_reg +: BYTE_W] = data_byte;

        if (bpp_eff >= BPP_SWAP) begin
            px = {bytes_ins[31:24], bytes_ins[7:0], bytes_ins[15:8], bytes_ins[23:16]};
        end else begin
            px = bytes_ins;
        end

        if (rle_enable_reg && repeat_reg) begin
            run_raw = packet_left_reg;
        end else begin
            run_raw = RUN_W'(1);
        end

        if (COUNT_WIDTH'(run_raw) > remaining_reg) begin
            run_clip = remaining_reg[RUN_W-1:0];
        end else begin
            run_clip = run_raw;
        end
        remaining_sub = remaining_reg - COUNT_WIDTH'(run_clip);

        res.pixel_value = px;
        res.run_length  = run_clip;
        res.last_run    = (remaining_sub == '0);

        if (cfg_we) begin
            case (cfg_index)
                REG_RLE_ENABLE: begin
                    rle_enable_next = cfg_data[0];
                end
                REG_BYTES_PER_PX: begin
                    bpp_next = cfg_data[BPP_W-1:0];
                end
                REG_IMAGE_PIXELS: begin
                    remaining_next = cfg_data;
                    done_next      = (cfg_data == '0);
                end
                default: begin
                end
            endcase
        end else if (item_accept && !done_reg) begin
            if (rle_enable_reg && packet_left_reg == '0) begin
                packet_left_next = {1'b0, data_byte[6:0]} + RUN_W'(1);
                repeat_next      = data_byte[7];
            end else if ({1'b0, byte_pos_reg} + BPP_W'(1) < bpp_eff) begin
                pixel_bytes_next = bytes_ins;
                byte_pos_next    = byte_pos_reg + POS_W'(1);
            end else begin
                pixel_bytes_next = '0;
                byte_pos_next    = '0;
                if (rle_enable_reg && repeat_reg) begin
                    packet_left_next = '0;
                end else if (rle_enable_reg && packet_left_reg != '0) begin
                    packet_left_next = packet_left_reg - RUN_W'(1);
                end
                remaining_next = remaining_sub;
                if (remaining_sub == '0) begin
                    done_next = 1'b1;
                end
                res_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_enable_reg  <= 1'b0;
            bpp_reg         <= BPP_RESET;
            packet_left_reg <= '0;
            repeat_reg      <= 1'b0;
            pixel_bytes_reg <= '0;
            byte_pos_reg    <= '0;
            remaining_reg   <= COUNT_WIDTH'(1);
            done_reg        <= 1'b0;
        end else begin
            rle_enable_reg  <= rle_enable_next;
            bpp_reg         <= bpp_next;
            packet_left_reg <= packet_left_next;
            repeat_reg      <= repeat_next;
            pixel_bytes_reg <= pixel_bytes_next;
            byte_pos_reg    <= byte_pos_next;
            remaining_reg   <= remaining_next;
            done_reg        <= done_next;
        end
    end

endmodule

@@ rtl/trpd_out_reg.sv @@
module trpd_out_reg import trpd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_res,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                res_next = in_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

@@ rtl/tga_rle_pixel_decoder.sv @@
// Channel   Direction  Payload
// s_        in         tdata[7:0] data_byte
// m_        out        tdata[31:0] pixel_value, tdata[39:32] run_length; tlast last_run
// cfg_      in         cfg_index register number, cfg_data value
//
// One byte is accepted per cycle while s_tready is high. The decode state and the output
// register both load at the accepting edge, so a result is offered the next cycle.
// The output register is the only buffer: s_tready drops while a result waits and
// m_tready is low, and while cfg_valid is high. Config writes are always ready.
// aresetn is synchronous, active low; no clearing pass.
module tga_rle_pixel_decoder import trpd_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,   // [31:0] pixel_value, [39:32] run_length
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0] cfg_data
);

    logic    item_accept;
    logic    out_room;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready   = 1'b1;
    assign s_tready    = out_room && !cfg_valid;
    assign item_accept = s_tvalid && s_tready;

    trpd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .data_byte   (s_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    trpd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (out_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.run_length, out_res.pixel_value};
    assign m_tlast = out_res.last_run;

endmodule

@@ bench/tb_tga_rle_pixel_decoder.sv @@
module tb_tga_rle_pixel_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import trpd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1900;
    localparam int CALM_FROM   = 1650;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 4;

    class pixel_run_tracker;
        bit                       rle;
        bit [BPP_W-1:0]           bpp;
        bit [COUNT_WIDTH_DEF-1:0] left_in_image;
        bit                       image_done;
        bit [7:0]                 packet_left;
        bit                       repeat_pkt;
        bit [31:0]                gather;
        bit [POS_W-1:0]           byte_pos;
        result_t                  runs_due[$];
        int                       errors;

        function new();
            rle           = 1'b0;
            bpp           = BPP_RESET;
            left_in_image = 1;
            image_done    = 1'b0;
            packet_left   = '0;
            repeat_pkt    = 1'b0;
            gather        = '0;
            byte_pos      = '0;
            errors        = 0;
        endfunction

        function int eff_bytes();
            if (bpp == 0) return int'(BPP_MIN);
            if (bpp > BPP_MAX) return int'(BPP_MAX);
            return int'(bpp);
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_WIDTH_DEF-1:0] value);
            case (idx)
                REG_RLE_ENABLE:   rle = value[0];
                REG_BYTES_PER_PX: bpp = value[BPP_W-1:0];
                REG_IMAGE_PIXELS: begin
                    left_in_image = value;
                    image_done    = (value == 0);
                end
                default: ;
            endcase
        endfunction

        // returns 1 when the byte is consumed, 0 when ignored after the image
        function bit note_byte(logic [7:0] b);
            int      eff;
            int      run;
            bit [31:0] px;
            result_t r;
            if (image_done) return 1'b0;
            if (rle && packet_left == 0) begin
                packet_left = {1'b0, b[6:0]} + 8'd1;
                repeat_pkt  = b[7];
                return 1'b1;
            end
            eff = eff_bytes();
            gather[8*byte_pos +: 8] = b;
            if (int'(byte_pos) + 1 < eff) begin
                byte_pos++;
                return 1'b1;
            end
            px       = gather;
            gather   = '0;
            byte_pos = '0;
            if (eff >= BPP_SWAP) px = {px[31:24], px[7:0], px[15:8], px[23:16]};
            if (rle && repeat_pkt) begin
                run         = int'(packet_left);
                packet_left = '0;
            end else begin
                run = 1;
                if (rle && packet_left > 0) packet_left--;
            end
            if (run > int'(left_in_image)) run = int'(left_in_image);
            left_in_image -= COUNT_WIDTH_DEF'(run);
            if (left_in_image == 0) image_done = 1'b1;
            r.pixel_value = px;
            r.run_length  = run[7:0];
            r.last_run    = image_done;
            runs_due = {runs_due, r};
            return 1'b1;
        endfunction

        function void check_run(logic [31:0] px, logic [7:0] run, logic last);
            result_t want;
            if (runs_due.size() == 0) begin
                $error("unexpected run: pixel_value %h run_length %0d last_run %0b",
                       px, run, last);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            if (px !== want.pixel_value) begin
                $error("pixel_value: expected %h, got %h", want.pixel_value, px);
                errors++;
            end
            if (run !== want.run_length) begin
                $error("run_length: expected %0d, got %0d", want.run_length, run);
                errors++;
            end
            if (last !== want.last_run) begin
                $error("last_run: expected %0b, got %0b", want.last_run, last);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;   // [7:0] data_byte
    logic                       m_tvalid;
    logic                       m_tready;
    logic [39:0]                m_tdata;   // [31:0] pixel_value, [39:32] run_length
    logic                       m_tlast;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [COUNT_WIDTH_DEF-1:0] cfg_data;

    pixel_run_tracker sb;
    int  bytes_decoded;
    int  quiet_cycles;
    int  out_hold;
    bit  calm_tail;
    bit  steady_in;
    bit  steady_out;

    tga_rle_pixel_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        if (calm_tail || !aresetn) begin
            m_tready = 1'b1;
        end else if (out_hold > 0) begin
            m_tready = 1'b0;
            out_hold--;
        end else if (!steady_out && $urandom_range(0, 5) == 0) begin
            out_hold = int'($urandom_range(0, 6));
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_run(m_tdata[31:0], m_tdata[39:32], m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (!calm_tail && !steady_in && $urandom_range(0, 7) == 0) begin
            gap = int'($urandom_range(1, 7));
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_byte(b)) bytes_decoded++;
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.runs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [COUNT_WIDTH_DEF-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int target);
        int         sent;
        int         n;
        logic [7:0] hdr;
        sent = 0;
        while (sent < target && !sb.image_done) begin
            if (sb.rle && $urandom_range(0, 9) != 0) begin
                hdr[7] = 1'($urandom_range(0, 1));
                if (hdr[7] || $urandom_range(0, 15) == 0)
                    hdr[6:0] = 7'($urandom_range(0, 127));
                else
                    hdr[6:0] = 7'($urandom_range(0, 7));
                send_byte(hdr);
                n = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
                repeat (n * sb.eff_bytes()) send_byte(rand_byte());
                sent += 1 + n * sb.eff_bytes();
            end else begin
                send_byte(rand_byte());
                sent++;
            end
        end
        if (sb.image_done)
            repeat ($urandom_range(1, 3)) send_byte(rand_byte());
    endtask

    task automatic configure_phase();
        logic [COUNT_WIDTH_DEF-1:0] pixels;
        wait_drain();
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_RLE_ENABLE, COUNT_WIDTH_DEF'($urandom));
        if ($urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_BYTES_PER_PX, COUNT_WIDTH_DEF'($urandom));
            else
                write_reg(REG_BYTES_PER_PX, COUNT_WIDTH_DEF'($urandom_range(1, 4)));
        end
        if (sb.image_done || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 19))
                0:       pixels = '0;
                1:       pixels = '1;
                2:       pixels = 1;
                default: pixels = COUNT_WIDTH_DEF'($urandom_range(2, 150));
            endcase
            write_reg(REG_IMAGE_PIXELS, pixels);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_SPARE, COUNT_WIDTH_DEF'($urandom));
        steady_in  = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        sb            = new();
        bytes_decoded = 0;
        quiet_cycles  = 0;
        out_hold      = 0;
        calm_tail     = 1'b0;
        steady_in     = 1'b0;
        steady_out    = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = REG_RLE_ENABLE;
        cfg_data      = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: plain, 4 bytes, one pixel, then a byte past the image
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hC3);

        // full-length repeats around a single raw, then a repeat clipped at the image end
        wait_drain();
        write_reg(REG_RLE_ENABLE, 1);
        write_reg(REG_BYTES_PER_PX, 3);
        write_reg(REG_IMAGE_PIXELS, 300);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'hFF);
        send_byte(8'hAB);
        send_byte(8'hCD);
        send_byte(8'hEF);

        // empty image swallows input; unmapped index is a no-op
        wait_drain();
        write_reg(REG_IMAGE_PIXELS, 0);
        send_byte(8'h3C);
        wait_drain();
        write_reg(REG_SPARE, '1);

        while (bytes_decoded < ITEM_TARGET) begin
            configure_phase();
            run_phase(int'($urandom_range(40, 160)));
            if (bytes_decoded >= CALM_FROM) calm_tail = 1'b1;
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
